FILE: rtl/core/ffua_pkg.sv
package ffua_pkg;

    localparam int MAX_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [10:0] alloc_size;
        logic [15:0] owner_id;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  start_unit;
        logic [10:0] freed_units;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic clear_hit;
        logic write_en;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/ffua_cell.sv
module ffua_cell #(
    parameter int OWNER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffua_pkg::cell_ctrl_t  ctrl,
    input  logic [OWNER_BITS-1:0] tag_in,
    input  logic [OWNER_BITS-1:0] wr_tag,
    input  logic [OWNER_BITS-1:0] match_tag,
    output logic [OWNER_BITS-1:0] tag_out
);
    import ffua_pkg::*;

    logic [OWNER_BITS-1:0] tag_reg;
    logic [OWNER_BITS-1:0] tag_next;
    logic [OWNER_BITS-1:0] moved;

    always_comb
    begin
        moved = tag_in;
        if (ctrl.write_en)
        begin
            moved = wr_tag;
        end
        else if (ctrl.clear_hit && tag_in == match_tag)
        begin
            moved = '0;
        end
        tag_next = ctrl.shift ? moved : tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    assign tag_out = tag_reg;
endmodule

FILE: rtl/core/first_fit_unit_allocator_unit.sv
// Owner tags sit in a ring of MAX_UNITS cells that rotates one place per
// cycle while a request is in its scan or mark state. An allocate request
// that finds a run takes two full rotations: the first finds the lowest free
// run, the second tags the chosen units as they pass the head cell. A free
// request, an allocate that finds no run and a request with owner zero take
// one rotation. After the last rotation a done state loads the result into
// an output register, where it is held, and the next item is accepted in the
// cycle after that result leaves. Units at or beyond the configured pool size
// (cfg_data, capped at MAX_UNITS) rotate untouched.
module first_fit_unit_allocator_unit #(
    parameter int MAX_UNITS  = ffua_pkg::MAX_UNITS_DEF,
    parameter int OWNER_BITS = ffua_pkg::OWNER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ffua_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ffua_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [10:0]   cfg_data
);
    import ffua_pkg::*;

    localparam int CW = ($clog2(MAX_UNITS + 1) + 1 > 12) ? $clog2(MAX_UNITS + 1) + 1 : 12;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [10:0]           pool_reg;
    logic                  act_reg;
    logic [CW-1:0]         size_reg;
    logic [OWNER_BITS-1:0] own_reg;
    logic [CW-1:0]         run_len_reg, run_len_next;
    logic [CW-1:0]         run_st_reg, run_st_next;
    logic                  fnd_reg, fnd_next;
    logic [CW-1:0]         freed_reg, freed_next;
    logic                  ovalid_reg;
    rsp_t                  odata_reg;

    logic [OWNER_BITS-1:0] tags [MAX_UNITS];
    logic [OWNER_BITS-1:0] head;
    logic [CW-1:0]         n_act;
    logic                  in_pool;
    cell_ctrl_t            ctrl0, ctrln;
    logic                  accept;

    assign head     = tags[MAX_UNITS-1];
    assign n_act    = ({{(CW-11){1'b0}}, pool_reg} > CW'(MAX_UNITS))
                      ? CW'(MAX_UNITS) : {{(CW-11){1'b0}}, pool_reg};
    assign in_pool  = pos_reg < n_act;
    assign in_stall = (state_reg != ST_IDLE) || ovalid_reg;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctrln = '{shift: (state_reg == ST_SCAN || state_reg == ST_MARK),
                  clear_hit: 1'b0, write_en: 1'b0};
        ctrl0 = ctrln;
        if (state_reg == ST_SCAN && act_reg == ACT_FREE && in_pool)
        begin
            ctrl0.clear_hit = 1'b1;
        end
        if (state_reg == ST_MARK && in_pool && pos_reg >= run_st_reg
            && pos_reg < run_st_reg + size_reg)
        begin
            ctrl0.write_en = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_UNITS; g++)
        begin : g_cell
            ffua_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      ((g == 0) ? ctrl0 : ctrln),
                .tag_in    ((g == 0) ? head : tags[(g == 0) ? 0 : g-1]),
                .wr_tag    (own_reg),
                .match_tag (own_reg),
                .tag_out   (tags[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        run_len_next = run_len_reg;
        run_st_next  = run_st_reg;
        fnd_next     = fnd_reg;
        freed_next   = freed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next     = '0;
                    run_len_next = '0;
                    run_st_next  = '0;
                    fnd_next     = 1'b0;
                    freed_next   = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (in_pool && own_reg != '0)
                begin
                    if (act_reg == ACT_FREE)
                    begin
                        if (head == own_reg)
                        begin
                            freed_next = freed_reg + 1'b1;
                        end
                    end
                    else if (!fnd_reg)
                    begin
                        if (head != '0)
                        begin
                            run_len_next = '0;
                        end
                        else
                        begin
                            if (run_len_reg == '0)
                            begin
                                run_st_next = pos_reg;
                            end
                            run_len_next = run_len_reg + 1'b1;
                            if (run_len_reg + 1'b1 >= size_reg)
                            begin
                                fnd_next = 1'b1;
                            end
                        end
                    end
                end
                pos_next = pos_reg + 1'b1;
                if (pos_reg == CW'(MAX_UNITS - 1))
                begin
                    pos_next   = '0;
                    state_next = (act_reg == ACT_ALLOC && fnd_next) ? ST_MARK : ST_DONE;
                end
            end
            ST_MARK:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == CW'(MAX_UNITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            pool_reg   <= 11'd1024;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
            begin
                pool_reg <= cfg_data;
            end
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_len_reg <= run_len_next;
        run_st_reg  <= run_st_next;
        fnd_reg     <= fnd_next;
        freed_reg   <= freed_next;
        if (accept)
        begin
            act_reg  <= in_data.action;
            size_reg <= CW'(in_data.alloc_size);
            own_reg  <= OWNER_BITS'(in_data.owner_id);
        end
        if (state_reg == ST_DONE)
        begin
            odata_reg.found       <= fnd_reg && act_reg == ACT_ALLOC && own_reg != '0;
            odata_reg.start_unit  <= (fnd_reg && act_reg == ACT_ALLOC && own_reg != '0)
                                     ? run_st_reg[9:0] : 10'd0;
            odata_reg.freed_units <= (act_reg == ACT_FREE) ? freed_reg[10:0] : 11'd0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
endmodule
